### rtl/smrc_pkg.sv
package smrc_pkg;

	localparam int MAX_N_DEF     = 16;
	localparam int ELEM_BITS_DEF = 32;
	localparam int DATA_BITS     = 32;
	localparam int OP_BITS       = 2;
	localparam int SIZE_BITS     = 5;
	localparam int SIZE_RESET    = 16;

	localparam logic [OP_BITS-1:0] OP_LOAD   = 2'd0;
	localparam logic [OP_BITS-1:0] OP_ROTATE = 2'd1;
	localparam logic [OP_BITS-1:0] OP_READ   = 2'd2;
	localparam logic [OP_BITS-1:0] OP_NONE   = 2'd3;

	localparam logic CFG_COLS = 1'b0;
	localparam logic CFG_ROWS = 1'b1;

endpackage

### rtl/square_matrix_rotate_clockwise.sv
// Channel   | Direction | Handshake                 | Payload
// ----------+-----------+---------------------------+----------------------------------
// command   | in        | start, busy               | op, elem_in
// result    | out       | done (one-cycle strobe)   | elem_out, last_elem, status
// config    | in        | cfg_valid, cfg_ready      | cfg_index, cfg_data
//
// A load writes the memory at dispatch. A read goes through a memory read and then the
// result register. A rotate of an n by n matrix with n of at least 2 runs floor(n*n/4)
// four-way swaps, each sharing the single read port and the single write port.
// A rotate of a one by one or a non-square matrix raises done straight from dispatch.
// After reset and every configuration write, the next command first passes through TOTAL,
// CLAMP and DIV, recomputing row and column of both positions by repeated subtraction.
// The matrix memory has no reset and no clearing pass. Results cannot be held off: done
// is high for exactly one cycle per result.
module square_matrix_rotate_clockwise #(
	parameter int MAX_N     = smrc_pkg::MAX_N_DEF,
	parameter int ELEM_BITS = smrc_pkg::ELEM_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [smrc_pkg::OP_BITS-1:0]        op,
	input  logic signed [smrc_pkg::DATA_BITS-1:0] elem_in,
	output logic                                done,
	output logic signed [smrc_pkg::DATA_BITS-1:0] elem_out,
	output logic                                last_elem,
	output logic                                status,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic                                cfg_index,
	input  logic [smrc_pkg::SIZE_BITS-1:0]      cfg_data
);
	import smrc_pkg::*;

	localparam int IDX_BITS = $clog2(MAX_N);
	localparam int CNT_BITS = $clog2(MAX_N + 1);
	localparam int DEPTH    = MAX_N * MAX_N;
	localparam int AW       = $clog2(DEPTH);
	localparam int TW       = AW + 1;
	localparam logic [CNT_BITS-1:0] SIZE_RST =
		CNT_BITS'((SIZE_RESET > MAX_N) ? MAX_N : SIZE_RESET);

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_TOTAL  = 4'd1;
	localparam logic [3:0] ST_CLAMP  = 4'd2;
	localparam logic [3:0] ST_DIV    = 4'd3;
	localparam logic [3:0] ST_EXEC   = 4'd4;
	localparam logic [3:0] ST_READ   = 4'd5;
	localparam logic [3:0] ST_ROT    = 4'd6;
	localparam logic [3:0] ST_DRAIN0 = 4'd7;
	localparam logic [3:0] ST_DRAIN1 = 4'd8;

	function automatic logic [CNT_BITS-1:0] clamp_size(input logic [SIZE_BITS-1:0] v);
		logic [CNT_BITS-1:0] r;
		if (v == '0) begin
			r = CNT_BITS'(1);
		end else if (32'(v) > 32'(MAX_N)) begin
			r = CNT_BITS'(MAX_N);
		end else begin
			r = CNT_BITS'(v);
		end
		return r;
	endfunction

	function automatic logic [AW-1:0] addr_of(input logic [IDX_BITS-1:0] r,
		input logic [IDX_BITS-1:0] c);
		return AW'(32'(r) * MAX_N + 32'(c));
	endfunction

	logic [ELEM_BITS-1:0] store_mem [DEPTH];
	logic [ELEM_BITS-1:0] rdata_q;
	logic                 we;
	logic [AW-1:0]        waddr;
	logic [AW-1:0]        raddr;
	logic [ELEM_BITS-1:0] wdata;

	logic [3:0]          state_q;
	logic                dirty_q;
	logic [CNT_BITS-1:0] cols_q;
	logic [CNT_BITS-1:0] rows_q;
	logic [TW-1:0]       total_q;
	logic [AW-1:0]       lpos_q;
	logic [AW-1:0]       rpos_q;
	logic [IDX_BITS-1:0] lrow_q;
	logic [IDX_BITS-1:0] lcol_q;
	logic [IDX_BITS-1:0] rrow_q;
	logic [IDX_BITS-1:0] rcol_q;
	logic [AW-1:0]       lrem_q;
	logic [AW-1:0]       rrem_q;
	logic [OP_BITS-1:0]  op_q;
	logic [DATA_BITS-1:0] elem_q;
	logic [IDX_BITS-1:0] ring_q;
	logic [IDX_BITS-1:0] k_q;
	logic [1:0]          phase_q;
	logic                pend_q;
	logic [ELEM_BITS-1:0] tmp_q;
	logic [AW-1:0]       caddr_q;
	logic [AW-1:0]       daddr_q;
	logic                done_q;
	logic signed [DATA_BITS-1:0] elem_out_q;
	logic                last_q;
	logic                status_q;

	logic                 disp_go;
	logic [OP_BITS-1:0]   disp_op;
	logic [DATA_BITS-1:0] disp_elem;
	logic [ELEM_BITS-1:0] load_word;
	logic [DATA_BITS-1:0] read_word;
	logic [IDX_BITS-1:0]  cols_m1;
	logic [AW-1:0]        total_m1;
	logic                 lwrap;
	logic                 rwrap;
	logic                 lmore;
	logic                 rmore;
	logic                 load_last;
	logic                 read_last;
	logic                 square;
	logic [CNT_BITS-1:0]  half;
	logic [IDX_BITS-1:0]  hi;
	logic [IDX_BITS-1:0]  span;
	logic [AW-1:0]        a_addr;
	logic [AW-1:0]        b_addr;
	logic [AW-1:0]        c_addr;
	logic [AW-1:0]        d_addr;
	logic                 k_end;
	logic                 ring_end;

	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = (state_q == ST_IDLE);
	assign done      = done_q;
	assign elem_out  = elem_out_q;
	assign last_elem = last_q;
	assign status    = status_q;

	assign disp_go   = ((state_q == ST_IDLE) && start && !dirty_q) || (state_q == ST_EXEC);
	assign disp_op   = (state_q == ST_EXEC) ? op_q : op;
	assign disp_elem = (state_q == ST_EXEC) ? elem_q : elem_in;

	generate
		if (ELEM_BITS >= DATA_BITS) begin : g_wide
			assign load_word = ELEM_BITS'(disp_elem);
			assign read_word = DATA_BITS'(rdata_q);
		end else begin : g_narrow
			assign load_word = disp_elem[ELEM_BITS-1:0];
			assign read_word = DATA_BITS'($signed(rdata_q));
		end
	endgenerate

	assign cols_m1   = IDX_BITS'(cols_q - 1'b1);
	assign total_m1  = AW'(total_q - 1'b1);
	assign lwrap     = (TW'(lpos_q) >= total_q);
	assign rwrap     = (TW'(rpos_q) >= total_q);
	assign lmore     = (lrem_q >= AW'(cols_q));
	assign rmore     = (rrem_q >= AW'(cols_q));
	assign load_last = (lpos_q == total_m1);
	assign read_last = (rpos_q == total_m1);
	assign square    = (cols_q == rows_q);
	assign half      = cols_q >> 1;

	// Ring geometry: ring_q is the ring number, hi the opposite edge of the same ring.
	assign hi       = cols_m1 - ring_q;
	assign span     = cols_m1 - IDX_BITS'(ring_q << 1);
	assign a_addr   = addr_of(ring_q, hi - k_q);
	assign b_addr   = addr_of(ring_q + k_q, ring_q);
	assign c_addr   = addr_of(hi, ring_q + k_q);
	assign d_addr   = addr_of(hi - k_q, hi);
	assign k_end    = (IDX_BITS'(k_q + 1'b1) == span);
	assign ring_end = ((CNT_BITS'(ring_q) + 1'b1) == half);

	// One swap spans four phases: A, B, C, D are read in phases 0 to 3. A and B are
	// written in phases 2 and 3, C and D in phases 0 and 1 of the next swap, or in drain.
	always_comb begin
		we    = 1'b0;
		waddr = addr_of(lrow_q, lcol_q);
		wdata = load_word;
		raddr = addr_of(rrow_q, rcol_q);
		priority if (state_q == ST_ROT) begin
			unique case (phase_q)
				2'd0: begin
					raddr = a_addr;
					we    = pend_q;
					waddr = caddr_q;
					wdata = rdata_q;
				end
				2'd1: begin
					raddr = b_addr;
					we    = pend_q;
					waddr = daddr_q;
					wdata = tmp_q;
				end
				2'd2: begin
					raddr = c_addr;
					we    = 1'b1;
					waddr = a_addr;
					wdata = rdata_q;
				end
				default: begin
					raddr = d_addr;
					we    = 1'b1;
					waddr = b_addr;
					wdata = rdata_q;
				end
			endcase
		end else if (state_q == ST_DRAIN0) begin
			we    = 1'b1;
			waddr = caddr_q;
			wdata = rdata_q;
		end else if (state_q == ST_DRAIN1) begin
			we    = 1'b1;
			waddr = daddr_q;
			wdata = tmp_q;
		end else if (disp_go && (disp_op == OP_LOAD)) begin
			we = 1'b1;
		end else begin
			we = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			store_mem[waddr] <= wdata;
		end
		rdata_q <= store_mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			dirty_q <= 1'b1;
			cols_q  <= SIZE_RST;
			rows_q  <= SIZE_RST;
			lpos_q  <= '0;
			lrow_q  <= '0;
			lcol_q  <= '0;
			rpos_q  <= '0;
			rrow_q  <= '0;
			rcol_q  <= '0;
			ring_q  <= '0;
			k_q     <= '0;
			phase_q <= '0;
			pend_q  <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				dirty_q <= 1'b1;
				if (cfg_index == CFG_COLS) begin
					cols_q <= clamp_size(cfg_data);
				end else begin
					rows_q <= clamp_size(cfg_data);
				end
			end

			unique case (state_q)
				ST_IDLE: begin
					if (start && dirty_q) begin
						state_q <= ST_TOTAL;
					end
				end
				ST_TOTAL: begin
					state_q <= ST_CLAMP;
				end
				ST_CLAMP: begin
					if (lwrap) begin
						lpos_q <= '0;
					end
					if (rwrap) begin
						rpos_q <= '0;
					end
					lrow_q  <= '0;
					rrow_q  <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (lmore) begin
						lrow_q <= lrow_q + 1'b1;
					end
					if (rmore) begin
						rrow_q <= rrow_q + 1'b1;
					end
					if (!lmore && !rmore) begin
						lcol_q  <= lrem_q[IDX_BITS-1:0];
						rcol_q  <= rrem_q[IDX_BITS-1:0];
						dirty_q <= 1'b0;
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					state_q <= ST_IDLE;
				end
				ST_READ: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				ST_ROT: begin
					phase_q <= phase_q + 1'b1;
					if (phase_q == 2'd3) begin
						pend_q <= 1'b1;
						if (k_end) begin
							k_q    <= '0;
							ring_q <= ring_q + 1'b1;
							if (ring_end) begin
								state_q <= ST_DRAIN0;
							end
						end else begin
							k_q <= k_q + 1'b1;
						end
					end
				end
				ST_DRAIN0: begin
					state_q <= ST_DRAIN1;
				end
				ST_DRAIN1: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (disp_go) begin
				unique case (disp_op)
					OP_LOAD: begin
						if (load_last) begin
							lpos_q <= '0;
							lrow_q <= '0;
							lcol_q <= '0;
						end else begin
							lpos_q <= lpos_q + 1'b1;
							if (lcol_q == cols_m1) begin
								lcol_q <= '0;
								lrow_q <= lrow_q + 1'b1;
							end else begin
								lcol_q <= lcol_q + 1'b1;
							end
						end
					end
					OP_ROTATE: begin
						if (square && (half != '0)) begin
							state_q <= ST_ROT;
							ring_q  <= '0;
							k_q     <= '0;
							phase_q <= '0;
							pend_q  <= 1'b0;
						end else begin
							done_q <= 1'b1;
						end
					end
					OP_READ: begin
						state_q <= ST_READ;
						if (read_last) begin
							rpos_q <= '0;
							rrow_q <= '0;
							rcol_q <= '0;
						end else begin
							rpos_q <= rpos_q + 1'b1;
							if (rcol_q == cols_m1) begin
								rcol_q <= '0;
								rrow_q <= rrow_q + 1'b1;
							end else begin
								rcol_q <= rcol_q + 1'b1;
							end
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			op_q   <= op;
			elem_q <= elem_in;
		end
		if (state_q == ST_TOTAL) begin
			total_q <= TW'(cols_q * rows_q);
		end
		if (state_q == ST_CLAMP) begin
			lrem_q <= lwrap ? '0 : lpos_q;
			rrem_q <= rwrap ? '0 : rpos_q;
		end
		if (state_q == ST_DIV) begin
			if (lmore) begin
				lrem_q <= lrem_q - AW'(cols_q);
			end
			if (rmore) begin
				rrem_q <= rrem_q - AW'(cols_q);
			end
		end
		if ((state_q == ST_ROT) && (phase_q == 2'd1)) begin
			tmp_q <= rdata_q;
		end
		if ((state_q == ST_ROT) && (phase_q == 2'd3)) begin
			caddr_q <= c_addr;
			daddr_q <= d_addr;
		end
		if (state_q == ST_READ) begin
			elem_out_q <= read_word;
		end
		if (disp_go && (disp_op == OP_READ)) begin
			last_q   <= read_last;
			status_q <= 1'b0;
		end
		if (disp_go && (disp_op == OP_ROTATE)) begin
			elem_out_q <= '0;
			last_q     <= 1'b0;
			status_q   <= !square;
		end
	end

endmodule

### sim/tb.sv
`timescale 1ns / 100ps

typedef struct {
	logic signed [smrc_pkg::DATA_BITS-1:0] elem;
	logic                                  last;
	logic                                  stat;
} matrix_result_t;

class matrix_scoreboard;
	localparam int SIDE     = smrc_pkg::MAX_N_DEF;
	localparam int REG_BITS = smrc_pkg::SIZE_BITS;

	logic signed [smrc_pkg::DATA_BITS-1:0] cells [SIDE*SIDE];
	bit                                    filled [SIDE*SIDE];
	int unsigned                           load_pos;
	int unsigned                           read_pos;
	logic [smrc_pkg::SIZE_BITS-1:0]        cols_reg;
	logic [smrc_pkg::SIZE_BITS-1:0]        rows_reg;
	matrix_result_t                        results_q [$];
	int                                    errors;

	function new();
		cols_reg = REG_BITS'(smrc_pkg::SIZE_RESET);
		rows_reg = REG_BITS'(smrc_pkg::SIZE_RESET);
		load_pos = 0;
		read_pos = 0;
		errors   = 0;
		foreach (filled[i]) filled[i] = 1'b0;
	endfunction

	// Out-of-range sizes clamp: zero acts as one, anything above the store side as the side.
	function int unsigned span(logic [smrc_pkg::SIZE_BITS-1:0] v);
		if (v == 0) return 1;
		if (v > SIDE) return SIDE;
		return 32'(v);
	endfunction

	function void set_reg(logic idx, logic [smrc_pkg::SIZE_BITS-1:0] v);
		if (idx == smrc_pkg::CFG_COLS) cols_reg = v;
		else rows_reg = v;
	endfunction

	function int pending();
		return results_q.size();
	endfunction

	// True when the entry that the next read would return has been written.
	function bit read_ready();
		int unsigned c, r, pos;
		c = span(cols_reg);
		r = span(rows_reg);
		pos = (read_pos >= c * r) ? 0 : read_pos;
		return filled[(pos / c) * SIDE + pos % c];
	endfunction

	function void note_input(logic [smrc_pkg::OP_BITS-1:0] code,
			logic signed [smrc_pkg::DATA_BITS-1:0] value);
		int unsigned c, r, total, pos;
		int i, j;
		logic signed [smrc_pkg::DATA_BITS-1:0] snap [SIDE*SIDE];
		bit snap_filled [SIDE*SIDE];
		matrix_result_t res;
		c = span(cols_reg);
		r = span(rows_reg);
		total = c * r;
		case (code)
			smrc_pkg::OP_LOAD: begin
				pos = (load_pos >= total) ? 0 : load_pos;
				cells[(pos / c) * SIDE + pos % c]  = value;
				filled[(pos / c) * SIDE + pos % c] = 1'b1;
				load_pos = (pos + 1 >= total) ? 0 : pos + 1;
			end
			smrc_pkg::OP_ROTATE: begin
				res.elem = '0;
				res.last = 1'b0;
				res.stat = (c != r);
				if (c == r) begin
					snap = cells;
					snap_filled = filled;
					for (i = 0; i < c; i++) begin
						for (j = 0; j < c; j++) begin
							cells[j * SIDE + c - 1 - i]  = snap[i * SIDE + j];
							filled[j * SIDE + c - 1 - i] = snap_filled[i * SIDE + j];
						end
					end
				end
				results_q.push_back(res);
			end
			smrc_pkg::OP_READ: begin
				pos = (read_pos >= total) ? 0 : read_pos;
				res.elem = cells[(pos / c) * SIDE + pos % c];
				res.last = (pos + 1 >= total);
				res.stat = 1'b0;
				read_pos = res.last ? 0 : pos + 1;
				results_q.push_back(res);
			end
			default: ;
		endcase
	endfunction

	task report(string msg);
		errors++;
		if (errors <= 50) $display("%0t mismatch: %s", $time, msg);
	endtask

	task check(logic signed [smrc_pkg::DATA_BITS-1:0] e, logic l, logic s);
		matrix_result_t want;
		if (results_q.size() == 0) begin
			report($sformatf("result with nothing expected: elem=%0d last=%0b status=%0b",
				e, l, s));
		end else begin
			want = results_q.pop_front();
			if (e !== want.elem)
				report($sformatf("elem_out %0d, expected %0d", e, want.elem));
			if (l !== want.last)
				report($sformatf("last_elem %0b, expected %0b", l, want.last));
			if (s !== want.stat)
				report($sformatf("status %0b, expected %0b", s, want.stat));
		end
	endtask

	task flush_leftovers();
		while (results_q.size() > 0) begin
			report($sformatf("missing result, expected elem=%0d last=%0b status=%0b",
				results_q[0].elem, results_q[0].last, results_q[0].stat));
			void'(results_q.pop_front());
		end
	endtask
endclass

module tb;
	import smrc_pkg::*;

	logic                        clk       = 1'b0;
	logic                        arst_n    = 1'b0;
	logic                        start     = 1'b0;
	logic                        busy;
	logic [OP_BITS-1:0]          op        = OP_NONE;
	logic signed [DATA_BITS-1:0] elem_in   = '0;
	logic                        done;
	logic signed [DATA_BITS-1:0] elem_out;
	logic                        last_elem;
	logic                        status;
	logic                        cfg_valid = 1'b0;
	logic                        cfg_ready;
	logic                        cfg_index = CFG_COLS;
	logic [SIZE_BITS-1:0]        cfg_data  = '0;

	matrix_scoreboard sb;
	int idle_pct [4] = '{0, 77, 0, 33};

	square_matrix_rotate_clockwise u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.op        (op),
		.elem_in   (elem_in),
		.done      (done),
		.elem_out  (elem_out),
		.last_elem (last_elem),
		.status    (status),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && done) sb.check(elem_out, last_elem, status);
	end

	function automatic logic [DATA_BITS-1:0] pick_value();
		case ($urandom_range(0, 9))
			0:       return 32'h8000_0000;
			1:       return 32'h7fff_ffff;
			2:       return '0;
			3:       return '1;
			default: return $urandom;
		endcase
	endfunction

	function automatic int pick_gap(int pct);
		return ($urandom_range(0, 99) < pct) ? $urandom_range(1, 5) : 0;
	endfunction

	// Called at a rising edge; returns at the edge where the command transfer happens.
	// Start is only lowered when a gap follows, so it never toggles within one step.
	task automatic send_item(logic [OP_BITS-1:0] code, logic [DATA_BITS-1:0] value, int gap);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start   <= 1'b1;
		op      <= code;
		elem_in <= value;
		do @(posedge clk); while (busy);
		sb.note_input(code, value);
	endtask

	task automatic drain();
		int k;
		start <= 1'b0;
		k = 0;
		while (sb.pending() > 0 && k < 5000) begin
			@(posedge clk);
			k++;
		end
		// Loads give no result and may still be finishing.
		repeat (8) @(posedge clk);
	endtask

	// Valid stays high across both transfers; only index and data change between them.
	task automatic write_sizes(logic [SIZE_BITS-1:0] c, logic [SIZE_BITS-1:0] r);
		logic rows_first;
		logic idx;
		int k;
		rows_first = 1'($urandom_range(0, 1));
		for (k = 0; k < 2; k++) begin
			idx = ((k == 0) == rows_first) ? CFG_ROWS : CFG_COLS;
			cfg_valid <= 1'b1;
			cfg_index <= idx;
			cfg_data  <= (idx == CFG_COLS) ? c : r;
			do @(posedge clk); while (!cfg_ready);
			sb.set_reg(idx, (idx == CFG_COLS) ? c : r);
		end
		cfg_valid <= 1'b0;
	endtask

	task automatic run_phase(logic [SIZE_BITS-1:0] c, logic [SIZE_BITS-1:0] r, int count,
			int pct);
		int k, total;
		logic [OP_BITS-1:0] code;
		drain();
		write_sizes(c, r);
		total = sb.span(c) * sb.span(r);
		for (k = 0; k < total; k++) send_item(OP_LOAD, pick_value(), pick_gap(pct));
		for (k = 0; k < count; k++) begin
			case ($urandom_range(0, 99)) inside
				[0:39]:  code = OP_READ;
				[40:74]: code = OP_LOAD;
				[75:87]: code = OP_ROTATE;
				default: code = OP_NONE;
			endcase
			if (code == OP_READ && !sb.read_ready()) code = OP_LOAD;
			send_item(code, pick_value(), pick_gap(pct));
		end
	endtask

	initial begin
		int p, k;
		logic [SIZE_BITS-1:0] c, r;
		sb = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Two by two: extreme values, read back, turn, read again, an idle opcode and a load.
		write_sizes(2, 2);
		send_item(OP_LOAD, 32'h8000_0000, 0);
		send_item(OP_LOAD, 32'h7fff_ffff, 0);
		send_item(OP_LOAD, 32'h0000_0000, 0);
		send_item(OP_LOAD, 32'hffff_ffff, 0);
		for (k = 0; k < 4; k++) send_item(OP_READ, 32'h5555_aaaa, 0);
		send_item(OP_ROTATE, 32'haaaa_5555, 0);
		for (k = 0; k < 4; k++) send_item(OP_READ, '0, 0);
		send_item(OP_NONE, 32'h1234_5678, 0);
		send_item(OP_LOAD, 32'h0000_0001, 0);
		// A three by two matrix is not square, so the turn is refused.
		drain();
		write_sizes(3, 2);
		send_item(OP_ROTATE, '0, 0);
		send_item(OP_READ, '0, 0);
		send_item(OP_READ, '0, 0);

		for (p = 0; p < 12; p++) begin
			case (p)
				3:  begin c = SIZE_BITS'(0);  r = SIZE_BITS'(0); end
				6:  begin c = SIZE_BITS'(1);  r = SIZE_BITS'($urandom_range(17, 31)); end
				9:  begin c = SIZE_BITS'(31); r = SIZE_BITS'(16); end
				default: begin
					c = SIZE_BITS'($urandom_range(1, 4));
					r = ($urandom_range(0, 9) < 6) ? c : SIZE_BITS'($urandom_range(1, 4));
					if ($urandom_range(0, 9) == 0) r = '0;
				end
			endcase
			run_phase(c, r, (p == 9) ? 24 : $urandom_range(4, 10), idle_pct[p % 4]);
		end

		drain();
		repeat (16) @(posedge clk);
		sb.flush_leftovers();
		if (sb.errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("end of test: mismatches");
		$finish;
	end
endmodule

### filelist.f
rtl/smrc_pkg.sv
rtl/square_matrix_rotate_clockwise.sv
sim/tb.sv
